/* rtl/ptft_pkg.sv */
package ptft_pkg;

    localparam int NUM_TOPICS  = 32;
    localparam int NUM_PORTS   = 16;
    localparam int TOPIC_W     = $clog2(NUM_TOPICS);
    localparam int PORT_W      = $clog2(NUM_PORTS);
    localparam int FUNC_W      = 3;
    localparam int KIND_W      = 3;
    localparam int CNT_W       = 5;

    // input message codes
    localparam logic [FUNC_W-1:0] F_SUBSCRIBE    = 3'd0;
    localparam logic [FUNC_W-1:0] F_BROKER_INIT  = 3'd1;
    localparam logic [FUNC_W-1:0] F_PUBLISH      = 3'd2;
    localparam logic [FUNC_W-1:0] F_CLIENT_LEAVE = 3'd3;
    localparam logic [FUNC_W-1:0] F_BROKER_LEAVE = 3'd4;
    localparam logic [FUNC_W-1:0] F_BROKER_JOIN  = 3'd5;
    localparam logic [FUNC_W-1:0] F_UNSUBSCRIBE  = 3'd6;
    localparam logic [FUNC_W-1:0] F_ACK_JOIN     = 3'd7;

    // emitted message codes
    localparam logic [KIND_W-1:0] K_SUBSCRIBE   = 3'd0;
    localparam logic [KIND_W-1:0] K_PUBLISH     = 3'd1;
    localparam logic [KIND_W-1:0] K_UNSUBSCRIBE = 3'd2;
    localparam logic [KIND_W-1:0] K_ACK_JOIN    = 3'd3;
    localparam logic [KIND_W-1:0] K_JOIN        = 3'd4;
    localparam logic [KIND_W-1:0] K_RELAY       = 3'd5;

    // datapath commands
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_ACC_IMM    = 3'd1;
    localparam logic [2:0] CMD_ACC_SINGLE = 3'd2;
    localparam logic [2:0] CMD_ACC_WALK   = 3'd3;
    localparam logic [2:0] CMD_EVAL       = 3'd4;
    localparam logic [2:0] CMD_WALK       = 3'd5;
    localparam logic [2:0] CMD_FLUSH      = 3'd6;

    typedef struct packed {
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic hub;
        logic in_active;
        logic in_broker;
        logic walk_last;
    } t_dp_stat;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [FUNC_W-1:0]    rf;
        logic [TOPIC_W-1:0]   topic;
        logic [NUM_PORTS-1:0] mask;
    } t_result;

endpackage

/* rtl/ptft_datapath.sv */
module ptft_datapath import ptft_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [PORT_W-1:0]    i_in_port,
    input  logic [TOPIC_W-1:0]   i_topic,
    input  logic                 i_cfg_we,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [KIND_W-1:0]    o_kind,
    output logic [FUNC_W-1:0]    o_relayed_func,
    output logic [TOPIC_W-1:0]   o_out_topic,
    output logic [NUM_PORTS-1:0] o_port_mask,
    output logic                 o_last
);

    logic [CNT_W-1:0]      r_port_count;
    logic [NUM_PORTS-1:0]  r_broker, n_broker;
    logic                  r_hub, n_hub;
    logic [NUM_TOPICS-1:0] r_valid, n_valid;
    logic [NUM_PORTS-1:0]  r_mem [NUM_TOPICS];
    logic [NUM_PORTS-1:0]  r_rdata;
    logic                  r_rvalid;
    logic [FUNC_W-1:0]     r_func;
    logic [PORT_W-1:0]     r_port;
    logic [TOPIC_W-1:0]    r_topic;
    logic [TOPIC_W-1:0]    r_idx, n_idx;
    logic                  r_pend_valid, n_pend_valid;
    t_result               r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;
    logic                  r_out_last, n_out_last;

    logic [CNT_W-1:0]      w_cnt;
    logic [NUM_PORTS:0]    w_act_wide;
    logic [NUM_PORTS-1:0]  w_act, w_in_pb, w_pb, w_d, w_wdata;
    logic [TOPIC_W-1:0]    w_t, w_raddr;
    logic                  w_we, w_has, w_tab_ok, w_tab_valid, w_imm_ok, w_imm_valid;
    t_result               w_tab, w_imm;

    // active port set from port_count, capped at the table width
    assign w_cnt      = (r_port_count > CNT_W'(NUM_PORTS)) ? CNT_W'(NUM_PORTS) : r_port_count;
    assign w_act_wide = ({{NUM_PORTS{1'b0}}, 1'b1} << w_cnt) - {{NUM_PORTS{1'b0}}, 1'b1};
    assign w_act      = w_act_wide[NUM_PORTS-1:0];
    assign w_in_pb    = ({{(NUM_PORTS-1){1'b0}}, 1'b1} << i_in_port) & w_act;
    assign w_pb       = ({{(NUM_PORTS-1){1'b0}}, 1'b1} << r_port) & w_act;

    assign o_stat.hub       = r_hub;
    assign o_stat.in_active = |w_in_pb;
    assign o_stat.in_broker = |(w_in_pb & r_broker);
    assign o_stat.walk_last = (r_idx == TOPIC_W'(NUM_TOPICS - 1));

    assign w_d   = r_rvalid ? r_rdata : '0;
    assign w_t   = (i_cmd.op == CMD_WALK) ? r_idx : r_topic;
    assign w_has = |(w_d & w_pb);

    // table entry evaluation, one topic per cycle
    always_comb begin
        w_tab_ok     = 1'b0;
        w_we         = 1'b0;
        w_wdata      = w_d;
        w_tab.kind   = K_SUBSCRIBE;
        w_tab.rf     = '0;
        w_tab.topic  = w_t;
        w_tab.mask   = '0;
        case (r_func)
            F_SUBSCRIBE: begin
                if (!w_has) begin
                    w_we       = 1'b1;
                    w_wdata    = w_d | w_pb;
                    w_tab_ok   = 1'b1;
                    w_tab.mask = r_broker & ~w_pb;
                end
            end
            F_PUBLISH: begin
                w_tab_ok   = 1'b1;
                w_tab.kind = K_PUBLISH;
                w_tab.mask = w_d & ~w_pb;
            end
            F_UNSUBSCRIBE, F_CLIENT_LEAVE: begin
                if (w_has) begin
                    w_we       = 1'b1;
                    w_wdata    = w_d & ~w_pb;
                    w_tab_ok   = ((w_d & ~w_pb) == '0);
                    w_tab.kind = K_UNSUBSCRIBE;
                    w_tab.mask = r_broker & ~w_pb;
                end
            end
            F_BROKER_INIT: begin
                w_tab_ok   = (w_d != '0);
                w_tab.mask = w_pb;
            end
            F_BROKER_JOIN: begin
                w_tab_ok   = (w_d != '0) && (w_d != w_pb);
                w_tab.mask = w_pb;
            end
            default: begin
                w_tab_ok = 1'b0;
            end
        endcase
        w_tab.mask  = w_tab.mask & w_act;
        w_tab_valid = w_tab_ok && (w_tab.mask != '0);
    end

    // hub mode relay and broker leave, straight from the input
    always_comb begin
        w_imm_ok    = 1'b0;
        n_hub       = r_hub;
        w_imm.kind  = K_RELAY;
        w_imm.rf    = '0;
        w_imm.topic = '0;
        w_imm.mask  = '0;
        if (r_hub) begin
            if (|w_in_pb) begin
                if (i_func == F_ACK_JOIN) begin
                    n_hub = 1'b0;
                end else if (i_func != F_UNSUBSCRIBE && i_func != F_BROKER_LEAVE) begin
                    w_imm_ok    = 1'b1;
                    w_imm.rf    = i_func;
                    w_imm.topic = i_topic;
                    w_imm.mask  = w_act & ~w_in_pb;
                end
            end
        end else if (i_func == F_BROKER_LEAVE) begin
            n_hub      = 1'b1;
            w_imm_ok   = 1'b1;
            w_imm.kind = K_JOIN;
            w_imm.mask = w_act;
        end
        w_imm_valid = w_imm_ok && (w_imm.mask != '0);
    end

    always_comb begin
        case (i_cmd.op)
            CMD_ACC_SINGLE: w_raddr = i_topic;
            CMD_ACC_WALK:   w_raddr = '0;
            CMD_WALK:       w_raddr = r_idx + TOPIC_W'(1);
            default:        w_raddr = r_topic;
        endcase
    end

    always_comb begin
        n_out_valid  = 1'b0;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_broker     = r_broker;
        n_valid      = r_valid;
        n_idx        = r_idx;
        case (i_cmd.op)
            CMD_ACC_IMM: begin
                if (!r_hub && i_func == F_BROKER_LEAVE) begin
                    n_valid = '0;
                end
                if (w_imm_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = w_imm;
                    n_out_last  = 1'b1;
                end
            end
            CMD_ACC_WALK: begin
                n_idx        = '0;
                n_pend_valid = (i_func == F_BROKER_JOIN);
                n_pend.kind  = K_ACK_JOIN;
                n_pend.rf    = '0;
                n_pend.topic = '0;
                n_pend.mask  = w_in_pb;
                if (i_func == F_BROKER_INIT || i_func == F_BROKER_JOIN) begin
                    n_broker = r_broker | w_in_pb;
                end
            end
            CMD_EVAL: begin
                if (w_we) begin
                    n_valid[w_t] = 1'b1;
                end
                if (w_tab_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = w_tab;
                    n_out_last  = 1'b1;
                end
            end
            CMD_WALK: begin
                n_idx = r_idx + TOPIC_W'(1);
                if (w_we) begin
                    n_valid[w_t] = 1'b1;
                end
                // hold one result back so the final one can carry last
                if (w_tab_valid) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend       = w_tab;
                end
            end
            CMD_FLUSH: begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_out_last  = 1'b1;
                end
                n_pend_valid = 1'b0;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (i_cmd.op == CMD_EVAL || i_cmd.op == CMD_WALK)) begin
            r_mem[w_t] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_ACC_IMM || i_cmd.op == CMD_ACC_SINGLE ||
            i_cmd.op == CMD_ACC_WALK) begin
            r_func  <= i_func;
            r_port  <= i_in_port;
            r_topic <= i_topic;
        end
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count <= CNT_W'(NUM_PORTS);
            r_broker     <= '0;
            r_hub        <= 1'b0;
            r_valid      <= '0;
            r_rvalid     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_port_count <= i_cfg_data;
            end
            r_broker     <= n_broker;
            if (i_cmd.op == CMD_ACC_IMM) begin
                r_hub <= n_hub;
            end
            r_valid      <= n_valid;
            r_rvalid     <= r_valid[w_raddr];
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_strobe       = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_relayed_func = r_out.rf;
    assign o_out_topic    = r_out.topic;
    assign o_port_mask    = r_out.mask;
    assign o_last         = r_out_last;

endmodule

/* rtl/ptft_ctrl.sv */
module ptft_ctrl import ptft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.hub || i_func == F_BROKER_LEAVE || !i_stat.in_active ||
                        i_func == F_ACK_JOIN ||
                        (i_func == F_CLIENT_LEAVE && i_stat.in_broker)) begin
                        o_cmd.op = CMD_ACC_IMM;
                    end else if (i_func == F_SUBSCRIBE || i_func == F_PUBLISH ||
                                 i_func == F_UNSUBSCRIBE) begin
                        o_cmd.op = CMD_ACC_SINGLE;
                        n_state  = S_EVAL;
                    end else begin
                        o_cmd.op = CMD_ACC_WALK;
                        n_state  = S_WALK;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.op = CMD_EVAL;
                n_state  = S_IDLE;
            end
            S_WALK: begin
                o_cmd.op = CMD_WALK;
                if (i_stat.walk_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.op = CMD_FLUSH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/pubsub_topic_forwarding_table.sv */
// topic forwarding table for one publish/subscribe broker node
//
// command channel: drive i_func, i_in_port and i_topic with start high; the
// message event is taken at a clock edge where start is high and busy is low
// results: each emitted message shows on the o_ result ports for one cycle
// with o_strobe high; o_last marks the final result of an event, and an event
// may emit no result at all; the receiver cannot stall the block
// config: i_cfg_data (port_count) is written when i_cfg_valid and o_cfg_ready
// are both high; ready is high whenever the block is not busy
// timing: hub-mode relay, broker leave and ignored events are decoded straight
// from the input and the result appears the cycle after acceptance; subscribe,
// publish and unsubscribe do one registered table read, then update; broker
// init, broker join and client leave walk every topic through the single table
// read port, each result held in a pending register so the final one carries o_last
// reset: synchronous active-low; subscriber table valid bits, broker ports
// and hub flag clear at once, port_count returns to 16
module pubsub_topic_forwarding_table import ptft_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [PORT_W-1:0]    i_in_port,
    input  logic [TOPIC_W-1:0]   i_topic,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [KIND_W-1:0]    o_kind,
    output logic [FUNC_W-1:0]    o_relayed_func,
    output logic [TOPIC_W-1:0]   o_out_topic,
    output logic [NUM_PORTS-1:0] o_port_mask,
    output logic                 o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = !busy;

    ptft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ptft_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_in_port      (i_in_port),
        .i_topic        (i_topic),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_relayed_func (o_relayed_func),
        .o_out_topic    (o_out_topic),
        .o_port_mask    (o_port_mask),
        .o_last         (o_last)
    );

endmodule

/* rtl/ptft_checker.sv */
module ptft_checker import ptft_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_strobe,
    input logic [KIND_W-1:0]    o_kind,
    input logic [FUNC_W-1:0]    o_relayed_func,
    input logic [TOPIC_W-1:0]   o_out_topic,
    input logic [NUM_PORTS-1:0] o_port_mask
);

    // no result right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // an emitted message always has a destination
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_port_mask != '0))
        else $error("result with empty port mask");

    // the relayed code is only carried by relay messages
    a_relay_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind != K_RELAY) |-> (o_relayed_func == '0))
        else $error("relayed func set on a non-relay result");

    // join and ack_join carry no topic
    a_no_topic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == K_JOIN || o_kind == K_ACK_JOIN)) |-> (o_out_topic == '0))
        else $error("topic on join or ack_join");

    // a transaction taken while idle never shows a result in the same cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !$past(start && !busy) && !$past(busy)) |-> !o_strobe)
        else $error("result without a prior transaction");

endmodule

bind pubsub_topic_forwarding_table ptft_checker u_ptft_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_kind         (o_kind),
    .o_relayed_func (o_relayed_func),
    .o_out_topic    (o_out_topic),
    .o_port_mask    (o_port_mask)
);

/* bench/tb_pubsub_topic_forwarding_table.sv */
`timescale 1ns / 100ps

module tb_pubsub_topic_forwarding_table;
    import ptft_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = NUM_TOPICS + 16;
    localparam int PHASES       = 6;
    localparam int PHASE_EVENTS = 37;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [FUNC_W-1:0]    rf;
        logic [TOPIC_W-1:0]   topic;
        logic [NUM_PORTS-1:0] mask;
        logic                 last;
    } fwd_msg_t;

    // one directed step: an event, or a port_count write when is_cfg is set
    typedef struct packed {
        logic                 is_cfg;
        logic [CNT_W-1:0]     cfg_val;
        logic [FUNC_W-1:0]    func;
        logic [PORT_W-1:0]    port;
        logic [TOPIC_W-1:0]   topic;
        logic                 typed;
        logic                 typed_one;
        fwd_msg_t             typed_msg;
    } step_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [PORT_W-1:0]    i_in_port = '0;
    logic [TOPIC_W-1:0]   i_topic = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 o_strobe;
    logic [KIND_W-1:0]    o_kind;
    logic [FUNC_W-1:0]    o_relayed_func;
    logic [TOPIC_W-1:0]   o_out_topic;
    logic [NUM_PORTS-1:0] o_port_mask;
    logic                 o_last;

    pubsub_topic_forwarding_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_in_port      (i_in_port),
        .i_topic        (i_topic),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_relayed_func (o_relayed_func),
        .o_out_topic    (o_out_topic),
        .o_port_mask    (o_port_mask),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    // forwarding table copy
    logic [NUM_PORTS-1:0] topic_subs [NUM_TOPICS];
    logic [NUM_PORTS-1:0] broker_ports;
    logic                 hub_active;
    logic [CNT_W-1:0]     ports_in_use;

    fwd_msg_t  fresh_msgs[$];
    fwd_msg_t  expected_msgs[$];
    step_row_t script[$];
    int        mismatches = 0;
    int        cycle_count = 0;

    function automatic logic [NUM_PORTS-1:0] active_set();
        logic [NUM_PORTS-1:0] one;
        one = 1;
        if (ports_in_use >= NUM_PORTS) return '1;
        return (one << ports_in_use) - 1'b1;
    endfunction

    function automatic void emit_msg(logic [KIND_W-1:0] kind, logic [FUNC_W-1:0] rf,
                                     logic [TOPIC_W-1:0] topic, logic [NUM_PORTS-1:0] mask);
        fwd_msg_t m;
        m.kind  = kind;
        m.rf    = rf;
        m.topic = topic;
        m.mask  = mask & active_set();
        m.last  = 1'b0;
        if (m.mask != '0) fresh_msgs.push_back(m);
    endfunction

    // clear a port from a topic, announce the topic's end if it empties
    function automatic void drop_port(int t, logic [NUM_PORTS-1:0] pb);
        if ((topic_subs[t] & pb) == '0) return;
        topic_subs[t] &= ~pb;
        if (topic_subs[t] == '0)
            emit_msg(K_UNSUBSCRIBE, '0, TOPIC_W'(t), broker_ports & ~pb);
    endfunction

    task automatic forward_event(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] p,
                                 input logic [TOPIC_W-1:0] t, output bit effective);
        logic [NUM_PORTS-1:0] act;
        logic [NUM_PORTS-1:0] pb;
        logic [NUM_PORTS-1:0] one;
        bit                   topic_ok;
        fwd_msg_t             tail;
        one = 1;
        act = active_set();
        pb = (one << p) & act;
        topic_ok = int'(t) < NUM_TOPICS;
        fresh_msgs.delete();
        effective = 1'b1;
        if (hub_active) begin
            if (pb == '0) begin
                effective = 1'b0;
            end else if (f == F_ACK_JOIN) begin
                hub_active = 1'b0;
            end else if (f == F_UNSUBSCRIBE || f == F_BROKER_LEAVE) begin
                effective = 1'b0;
            end else begin
                emit_msg(K_RELAY, f, t, act & ~pb);
            end
        end else if (f == F_BROKER_LEAVE) begin
            hub_active = 1'b1;
            for (int i = 0; i < NUM_TOPICS; i++) topic_subs[i] = '0;
            emit_msg(K_JOIN, '0, '0, act);
        end else if (pb == '0) begin
            effective = 1'b0;
        end else begin
            case (f)
                F_SUBSCRIBE: begin
                    if (topic_ok && (topic_subs[t] & pb) == '0) begin
                        topic_subs[t] |= pb;
                        emit_msg(K_SUBSCRIBE, '0, t, broker_ports & ~pb);
                    end
                end
                F_BROKER_INIT: begin
                    broker_ports |= pb;
                    for (int i = 0; i < NUM_TOPICS; i++)
                        if (topic_subs[i] != '0) emit_msg(K_SUBSCRIBE, '0, TOPIC_W'(i), pb);
                end
                F_PUBLISH: begin
                    if (topic_ok) emit_msg(K_PUBLISH, '0, t, topic_subs[t] & ~pb);
                end
                F_CLIENT_LEAVE: begin
                    if ((broker_ports & pb) == '0) begin
                        for (int i = 0; i < NUM_TOPICS; i++) drop_port(i, pb);
                    end else begin
                        effective = 1'b0;
                    end
                end
                F_BROKER_JOIN: begin
                    emit_msg(K_ACK_JOIN, '0, '0, pb);
                    broker_ports |= pb;
                    // a topic held only by the joining broker is not echoed back
                    for (int i = 0; i < NUM_TOPICS; i++)
                        if (topic_subs[i] != '0 && topic_subs[i] != pb)
                            emit_msg(K_SUBSCRIBE, '0, TOPIC_W'(i), pb);
                end
                F_UNSUBSCRIBE: begin
                    if (topic_ok) drop_port(int'(t), pb);
                end
                default: effective = 1'b0;
            endcase
        end
        if (fresh_msgs.size() > 0) begin
            tail = fresh_msgs.pop_back();
            tail.last = 1'b1;
            fresh_msgs.push_back(tail);
        end
    endtask

    task automatic commit_predicted();
        foreach (fresh_msgs[i]) expected_msgs.push_back(fresh_msgs[i]);
    endtask

    // start stays high after the transaction so back-to-back events need no toggle
    task automatic send_event(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] p,
                              input logic [TOPIC_W-1:0] t, output bit effective);
        start <= 1'b1;
        i_func <= f;
        i_in_port <= p;
        i_topic <= t;
        do @(posedge i_clk); while (busy);
        forward_event(f, p, t, effective);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_port_count(logic [CNT_W-1:0] v);
        wait_drained();
        // events with no result may still be walking the table
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ports_in_use = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic step_row_t ev(logic [FUNC_W-1:0] f, int p, int t);
        step_row_t r;
        r = '0;
        r.func = f;
        r.port = PORT_W'(p);
        r.topic = TOPIC_W'(t);
        return r;
    endfunction

    function automatic step_row_t ev_none(logic [FUNC_W-1:0] f, int p, int t);
        step_row_t r;
        r = ev(f, p, t);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic step_row_t ev_one(logic [FUNC_W-1:0] f, int p, int t,
                                         logic [KIND_W-1:0] kind, logic [FUNC_W-1:0] rf,
                                         int topic, logic [NUM_PORTS-1:0] mask);
        step_row_t r;
        r = ev_none(f, p, t);
        r.typed_one = 1'b1;
        r.typed_msg = '{kind, rf, TOPIC_W'(topic), mask, 1'b1};
        return r;
    endfunction

    function automatic step_row_t cfg_row(int v);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_val = CNT_W'(v);
        return r;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        if (hub_active && $urandom_range(0, 2) == 0) return F_ACK_JOIN;
        r = $urandom_range(0, 99);
        if (r < 30) return F_SUBSCRIBE;
        if (r < 55) return F_PUBLISH;
        if (r < 70) return F_UNSUBSCRIBE;
        if (r < 77) return F_CLIENT_LEAVE;
        if (r < 83) return F_BROKER_INIT;
        if (r < 89) return F_BROKER_JOIN;
        if (r < 93) return F_BROKER_LEAVE;
        return F_ACK_JOIN;
    endfunction

    function automatic void report_mismatch(string what, fwd_msg_t want, fwd_msg_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: exp kind %0d rf %0d topic %0d mask %h last %0d, got kind %0d rf %0d topic %0d mask %h last %0d",
                     what, want.kind, want.rf, want.topic, want.mask, want.last,
                     got.kind, got.rf, got.topic, got.mask, got.last);
    endfunction

    always @(posedge i_clk) begin : check_results
        fwd_msg_t got;
        fwd_msg_t want;
        if (i_rst_n && o_strobe) begin
            got = '{o_kind, o_relayed_func, o_out_topic, o_port_mask, o_last};
            if (expected_msgs.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_msgs.pop_front();
                if (got.kind !== want.kind) report_mismatch("kind", want, got);
                else if (got.rf !== want.rf) report_mismatch("relayed_func", want, got);
                else if (got.topic !== want.topic) report_mismatch("out_topic", want, got);
                else if (got.mask !== want.mask) report_mismatch("port_mask", want, got);
                else if (got.last !== want.last) report_mismatch("last", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0]   phase_counts [PHASES];
        logic [FUNC_W-1:0]  f;
        logic [PORT_W-1:0]  p;
        logic [TOPIC_W-1:0] t;
        bit                 effective;
        bit                 pressured;
        int                 done;
        int                 burst;
        int                 act_n;
        step_row_t          row;

        for (int i = 0; i < NUM_TOPICS; i++) topic_subs[i] = '0;
        broker_ports = '0;
        hub_active = 1'b0;
        ports_in_use = CNT_W'(16);
        pressured = 1'b0;

        script.push_back(ev_none(F_PUBLISH, 0, 0));
        script.push_back(ev_none(F_SUBSCRIBE, 0, 31));
        script.push_back(ev_one(F_BROKER_INIT, 15, 0, K_SUBSCRIBE, '0, 31, 16'h8000));
        script.push_back(ev_one(F_SUBSCRIBE, 3, 31, K_SUBSCRIBE, '0, 31, 16'h8000));
        script.push_back(ev_one(F_PUBLISH, 0, 31, K_PUBLISH, '0, 31, 16'h0008));
        script.push_back(ev(F_SUBSCRIBE, 5, 0));
        script.push_back(ev(F_SUBSCRIBE, 14, 7));
        script.push_back(ev(F_BROKER_JOIN, 14, 0));
        script.push_back(ev(F_UNSUBSCRIBE, 3, 31));
        script.push_back(ev_none(F_CLIENT_LEAVE, 15, 0));
        script.push_back(ev(F_CLIENT_LEAVE, 0, 0));
        script.push_back(ev(F_UNSUBSCRIBE, 5, 0));
        script.push_back(ev_none(F_ACK_JOIN, 2, 0));
        script.push_back(ev_one(F_BROKER_LEAVE, 9, 0, K_JOIN, '0, 0, 16'hFFFF));
        script.push_back(ev_one(F_PUBLISH, 2, 4, K_RELAY, F_PUBLISH, 4, 16'hFFFB));
        script.push_back(ev_none(F_UNSUBSCRIBE, 2, 4));
        script.push_back(ev_none(F_BROKER_LEAVE, 2, 0));
        script.push_back(ev_one(F_SUBSCRIBE, 15, 31, K_RELAY, F_SUBSCRIBE, 31, 16'h7FFF));
        script.push_back(ev_none(F_ACK_JOIN, 1, 0));
        script.push_back(ev_none(F_PUBLISH, 0, 7));
        script.push_back(cfg_row(4));
        script.push_back(ev_none(F_SUBSCRIBE, 8, 1));
        script.push_back(ev_one(F_BROKER_LEAVE, 10, 0, K_JOIN, '0, 0, 16'h000F));
        script.push_back(ev_none(F_ACK_JOIN, 10, 0));
        script.push_back(ev_one(F_CLIENT_LEAVE, 3, 0, K_RELAY, F_CLIENT_LEAVE, 0, 16'h0007));
        script.push_back(ev_none(F_ACK_JOIN, 3, 0));
        // a bit stored above a later port_count must never be a destination
        script.push_back(cfg_row(16));
        script.push_back(ev(F_SUBSCRIBE, 12, 2));
        script.push_back(cfg_row(1));
        script.push_back(ev_none(F_PUBLISH, 0, 2));
        script.push_back(ev_none(F_SUBSCRIBE, 0, 2));
        script.push_back(cfg_row(31));
        script.push_back(ev(F_BROKER_INIT, 3, 0));
        script.push_back(cfg_row(0));
        script.push_back(ev_none(F_SUBSCRIBE, 0, 5));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            row = script[i];
            if (row.is_cfg) begin
                write_port_count(row.cfg_val);
            end else begin
                send_event(row.func, row.port, row.topic, effective);
                if (!row.typed) commit_predicted();
                else if (row.typed_one) expected_msgs.push_back(row.typed_msg);
                if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
            end
        end

        phase_counts[0] = CNT_W'(16);
        phase_counts[1] = CNT_W'(31);
        phase_counts[2] = CNT_W'(9);
        phase_counts[3] = CNT_W'(1);
        phase_counts[4] = CNT_W'($urandom_range(2, 15));
        phase_counts[5] = CNT_W'(16);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_port_count(phase_counts[ph]);
            act_n = (ports_in_use > NUM_PORTS) ? NUM_PORTS : int'(ports_in_use);
            done = 0;
            burst = $urandom_range(1, 10);
            while (done < PHASE_EVENTS) begin
                f = pick_func();
                if (act_n == 0 || $urandom_range(0, 19) == 0) p = PORT_W'($urandom_range(0, 15));
                else p = PORT_W'($urandom_range(0, act_n - 1));
                if ($urandom_range(0, 3) == 0) t = TOPIC_W'($urandom_range(0, 31));
                else t = TOPIC_W'($urandom_range(0, 7));
                send_event(f, p, t, effective);
                commit_predicted();
                if (effective) done++;
                if (ph == 2 && done == 15 && !pressured) begin
                    pressured = 1'b1;
                    wait_drained();
                end
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 10);
                    // phases 1 and 4 keep the sender busy back to back
                    if (ph != 1 && ph != 4) begin
                        if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(13, 45));
                        else pause_sender($urandom_range(1, 12));
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_msgs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* pubsub_topic_forwarding_table.f */
rtl/ptft_pkg.sv
rtl/ptft_datapath.sv
rtl/ptft_ctrl.sv
rtl/pubsub_topic_forwarding_table.sv
rtl/ptft_checker.sv
bench/tb_pubsub_topic_forwarding_table.sv
